// ----- hw/rtl/point_segment_distance_assert.svh -----
// Assertion macros shared by the point-to-segment distance pipeline.
`ifndef POINT_SEGMENT_DISTANCE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSD_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define PSD_ASSERT(lbl, clk, rst, prop, msg)
`define PSD_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- hw/rtl/psd_pkg.sv -----
// Types and constants of the point-to-segment distance pipeline.
package psd_pkg;

   localparam int CoordW = 32;
   localparam int DiffW  = 33;
   localparam int ProdW  = 66;
   localparam int SumW   = 67;
   localparam int QBits  = 32;
   localparam int TW     = 33;
   localparam int ErrW   = 35;
   localparam int EMagW  = 34;
   localparam int SqW    = 68;
   localparam int RootW  = 34;
   localparam int DistW  = 33;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] seg_start_x;
      logic signed [CoordW-1:0] seg_start_y;
      logic signed [CoordW-1:0] seg_end_x;
      logic signed [CoordW-1:0] seg_end_y;
   } psd_req_type;

   typedef struct packed {
      logic [DistW-1:0] distance;
      logic             degenerate;
   } psd_rsp_type;

   // Offsets of the query point and the segment direction, relative to the start.
   typedef struct packed {
      logic signed [DiffW-1:0] px;
      logic signed [DiffW-1:0] py;
      logic signed [DiffW-1:0] dx;
      logic signed [DiffW-1:0] dy;
      logic                    degenerate;
   } psd_vec_type;

   typedef struct packed {
      psd_vec_type     vec;
      logic [SumW-1:0] len2;
      logic [SumW-1:0] dot;
      logic            t_zero;
      logic            t_one;
   } psd_proj_type;

   typedef struct packed {
      psd_vec_type   vec;
      logic [TW-1:0] t;
   } psd_param_type;

   typedef struct packed {
      logic [SqW-1:0] dist2;
      logic           degenerate;
   } psd_dist2_type;

   function automatic logic [DiffW-1:0] mag_diff(input logic signed [DiffW-1:0] v);
      mag_diff = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
   endfunction

endpackage

// ----- hw/rtl/psd_setup.sv -----
// Differences, squared length, dot product and saturation of the projection.
`include "point_segment_distance_assert.svh"
module psd_setup
   import psd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  psd_req_type  in_data,
   output logic         out_valid,
   output psd_proj_type out_data
);

   logic [4:0]        valid_ff;
   psd_vec_type       vec_ff [4];
   logic [DiffW-1:0]  mpx_ff, mpy_ff, mdx_ff, mdy_ff;
   logic [ProdW-1:0]  a_ff, b_ff, l1_ff, l2_ff;
   logic              na_ff, nb_ff;
   logic [SumW-1:0]   len2_ff, pos_ff, neg_ff, len2b_ff, dot_ff;
   logic              gt_ff;
   psd_proj_type      out_ff;
   psd_vec_type       vec_in;

   always_comb begin
      vec_in.px = {in_data.point_x[CoordW-1], in_data.point_x}
                - {in_data.seg_start_x[CoordW-1], in_data.seg_start_x};
      vec_in.py = {in_data.point_y[CoordW-1], in_data.point_y}
                - {in_data.seg_start_y[CoordW-1], in_data.seg_start_y};
      vec_in.dx = {in_data.seg_end_x[CoordW-1], in_data.seg_end_x}
                - {in_data.seg_start_x[CoordW-1], in_data.seg_start_x};
      vec_in.dy = {in_data.seg_end_y[CoordW-1], in_data.seg_end_y}
                - {in_data.seg_start_y[CoordW-1], in_data.seg_start_y};
      vec_in.degenerate = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff[0] <= vec_in;
         mpx_ff    <= mag_diff(vec_in.px);
         mpy_ff    <= mag_diff(vec_in.py);
         mdx_ff    <= mag_diff(vec_in.dx);
         mdy_ff    <= mag_diff(vec_in.dy);

         vec_ff[1] <= vec_ff[0];
         a_ff      <= mpx_ff * mdx_ff;
         b_ff      <= mpy_ff * mdy_ff;
         l1_ff     <= mdx_ff * mdx_ff;
         l2_ff     <= mdy_ff * mdy_ff;
         na_ff     <= vec_ff[0].px[DiffW-1] != vec_ff[0].dx[DiffW-1];
         nb_ff     <= vec_ff[0].py[DiffW-1] != vec_ff[0].dy[DiffW-1];

         vec_ff[2] <= vec_ff[1];
         len2_ff   <= SumW'(l1_ff) + SumW'(l2_ff);
         pos_ff    <= (na_ff ? '0 : SumW'(a_ff)) + (nb_ff ? '0 : SumW'(b_ff));
         neg_ff    <= (na_ff ? SumW'(a_ff) : '0) + (nb_ff ? SumW'(b_ff) : '0);

         vec_ff[3] <= {vec_ff[2].px, vec_ff[2].py, vec_ff[2].dx, vec_ff[2].dy,
                       len2_ff == '0};
         len2b_ff  <= len2_ff;
         gt_ff     <= pos_ff > neg_ff;
         dot_ff    <= pos_ff - neg_ff;

         out_ff.vec    <= vec_ff[3];
         out_ff.len2   <= len2b_ff;
         out_ff.dot    <= dot_ff;
         out_ff.t_zero <= !gt_ff;
         out_ff.t_one  <= gt_ff && (dot_ff >= len2b_ff);
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = out_ff;

   `PSD_ASSERT_IMPL(a_degen_t_zero, clock, reset, out_valid && out_data.vec.degenerate,
      out_data.t_zero, "zero-length segment with nonzero projection")

endmodule

// ----- hw/rtl/psd_divide.sv -----
// Restoring divider, one quotient bit per stage, for the projection parameter.
`include "point_segment_distance_assert.svh"
module psd_divide
   import psd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  psd_proj_type  in_data,
   output logic          out_valid,
   output psd_param_type out_data
);

   logic [QBits-1:0] valid_ff;
   psd_proj_type     st_ff  [QBits];
   logic [QBits-1:0] q_ff   [QBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[QBits-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QBits; k++) begin : g_step
      psd_proj_type     src;
      psd_proj_type     st_in;
      logic [QBits-1:0] qsrc;
      logic [SumW:0]    r2;
      logic             ge;

      if (k == 0) begin : g_first
         assign src  = in_data;
         assign qsrc = '0;
      end else begin : g_next
         assign src  = st_ff[k-1];
         assign qsrc = q_ff[k-1];
      end

      always_comb begin
         r2     = {src.dot, 1'b0};
         ge     = r2 >= {1'b0, src.len2};
         st_in  = src;
         st_in.dot = ge ? SumW'(r2 - {1'b0, src.len2}) : SumW'(r2);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in;
            q_ff[k]  <= {qsrc[QBits-2:0], ge};
         end
      end
   end

   always_comb begin
      out_data.vec = st_ff[QBits-1].vec;
      priority if (st_ff[QBits-1].t_one) begin
         out_data.t = TW'(1) << QBits;
      end else if (st_ff[QBits-1].t_zero) begin
         out_data.t = '0;
      end else begin
         out_data.t = {1'b0, q_ff[QBits-1]};
      end
   end

   assign out_valid = valid_ff[QBits-1];

   `PSD_ASSERT_IMPL(a_rem_below, clock, reset,
      out_valid && !st_ff[QBits-1].t_zero && !st_ff[QBits-1].t_one,
      st_ff[QBits-1].dot < st_ff[QBits-1].len2, "division remainder out of range")

endmodule

// ----- hw/rtl/psd_offset.sv -----
// Closest point offset, error vector and squared distance.
module psd_offset
   import psd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  psd_param_type in_data,
   output logic          out_valid,
   output psd_dist2_type out_data
);

   logic [5:0]         valid_ff;
   logic [5:0]         degen_ff;
   psd_vec_type        vec_ff [2];
   logic [DiffW-1:0]   mdx_ff, mdy_ff;
   logic [TW-1:0]      t_ff;
   logic [ProdW-1:0]   ox_ff, oy_ff;
   logic signed [ErrW-1:0] ex_ff, ey_ff;
   logic [EMagW-1:0]   mex_ff, mey_ff;
   logic [SqW-1:0]     sx_ff, sy_ff, d2_ff;
   logic [TW-1:0]      offx, offy;
   logic signed [ErrW-1:0] sox, soy, ex_in, ey_in;

   always_comb begin
      offx  = TW'((ProdW+1)'(ox_ff) + (ProdW+1)'(33'h080000000) >> QBits);
      offy  = TW'((ProdW+1)'(oy_ff) + (ProdW+1)'(33'h080000000) >> QBits);
      sox   = vec_ff[1].dx[DiffW-1] ? -ErrW'(offx) : ErrW'(offx);
      soy   = vec_ff[1].dy[DiffW-1] ? -ErrW'(offy) : ErrW'(offy);
      ex_in = ErrW'(vec_ff[1].px) - sox;
      ey_in = ErrW'(vec_ff[1].py) - soy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         degen_ff <= {degen_ff[4:0], in_data.vec.degenerate};
         vec_ff[0] <= in_data.vec;
         mdx_ff    <= mag_diff(in_data.vec.dx);
         mdy_ff    <= mag_diff(in_data.vec.dy);
         t_ff      <= in_data.t;

         vec_ff[1] <= vec_ff[0];
         ox_ff     <= mdx_ff * t_ff;
         oy_ff     <= mdy_ff * t_ff;

         ex_ff <= ex_in;
         ey_ff <= ey_in;

         mex_ff <= ex_ff[ErrW-1] ? EMagW'(-ex_ff) : EMagW'(ex_ff);
         mey_ff <= ey_ff[ErrW-1] ? EMagW'(-ey_ff) : EMagW'(ey_ff);

         sx_ff <= mex_ff * mex_ff;
         sy_ff <= mey_ff * mey_ff;

         d2_ff <= sx_ff + sy_ff;
      end
   end

   assign out_valid           = valid_ff[5];
   assign out_data.dist2      = d2_ff;
   assign out_data.degenerate = degen_ff[5];

endmodule

// ----- hw/rtl/psd_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per stage.
`include "point_segment_distance_assert.svh"
module psd_sqrt
   import psd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  psd_dist2_type in_data,
   output logic          out_valid,
   output psd_rsp_type   out_data
);

   logic [RootW-1:0] valid_ff;
   logic [RootW-1:0] degen_ff;
   logic [SqW-1:0]   rem_ff  [RootW];
   logic [RootW-1:0] root_ff [RootW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[RootW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         degen_ff <= {degen_ff[RootW-2:0], in_data.degenerate};
      end
   end

   for (genvar j = 0; j < RootW; j++) begin : g_step
      localparam int Bit = RootW - 1 - j;
      logic [SqW-1:0]   rsrc;
      logic [RootW-1:0] qsrc;
      logic [SqW-1:0]   inc;
      logic             ge;

      if (j == 0) begin : g_first
         assign rsrc = in_data.dist2;
         assign qsrc = '0;
      end else begin : g_next
         assign rsrc = rem_ff[j-1];
         assign qsrc = root_ff[j-1];
      end

      // (r + 2^i)^2 - r^2 with the low bits of r known to be zero.
      always_comb begin
         inc = (SqW'(qsrc) << (Bit + 1)) | (SqW'(1) << (2 * Bit));
         ge  = rsrc >= inc;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]  <= ge ? rsrc - inc : rsrc;
            root_ff[j] <= ge ? qsrc | (RootW'(1) << Bit) : qsrc;
         end
      end
   end

   assign out_valid           = valid_ff[RootW-1];
   assign out_data.distance   = root_ff[RootW-1][DistW-1:0];
   assign out_data.degenerate = degen_ff[RootW-1];

   `PSD_ASSERT_IMPL(a_root_floor, clock, reset, out_valid,
      (rem_ff[RootW-1] <= {root_ff[RootW-1], 1'b0}), "square root not the floor")

endmodule

// ----- hw/rtl/point_segment_distance.sv -----
// Top level of the point-to-segment distance pipeline.
// Each transfer on the req_ channel carries a query point and a segment's two end points in
// signed fixed point; the matching rsp_ transfer carries the Euclidean distance from the point
// to the nearest point of the segment, floor of the exact root, with the same number of
// fraction bits, plus a flag that is set when the segment has zero length (the distance is
// then measured to the start point). The block is a fully pipelined datapath that takes one
// transfer in every cycle while not stalled, and returns results in order: 5 stages form the
// differences, the squared length and the dot product, 32 stages of a restoring divider give
// the projection parameter one bit per stage, 6 stages form the closest point and the squared
// distance, and 34 stages of a digit-by-digit square root give one root bit each. There is no
// configuration and no state between items. When a result waits with rsp_stall high the whole
// pipeline holds, and req_stall is raised in the same cycle, so nothing is dropped or repeated.
module point_segment_distance
   import psd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  psd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output psd_rsp_type rsp_data
);

   logic          adv;
   logic          proj_valid, param_valid, dist2_valid;
   psd_proj_type  proj;
   psd_param_type param;
   psd_dist2_type dist2;

   // The pipeline moves whenever the output stage is empty or being taken.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   psd_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (proj_valid),
      .out_data  (proj)
   );

   psd_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (proj_valid),
      .in_data   (proj),
      .out_valid (param_valid),
      .out_data  (param)
   );

   psd_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (param_valid),
      .in_data   (param),
      .out_valid (dist2_valid),
      .out_data  (dist2)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dist2_valid),
      .in_data   (dist2),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// ----- tb/tb_point_segment_distance.sv -----
// Self-checking testbench for the point-to-segment distance pipeline.
`timescale 1ns / 100ps

module tb_point_segment_distance;
   import psd_pkg::*;

   // Holds the distances that the block still owes, in the order the queries were accepted.
   class distance_scoreboard;
      psd_rsp_type pending[$];
      int errors;

      // Magnitude of a signed value held in a wider vector.
      static function logic [63:0] abs64(input logic signed [63:0] v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      // Floor of the square root of a 128-bit value, one root bit per step.
      static function logic [63:0] root_floor(input logic [127:0] n);
         logic [127:0] res, bit_w, trial;
         res = 0;
         bit_w = 128'd1 << 126;
         while (bit_w != 0 && bit_w > n) bit_w = bit_w >> 2;
         while (bit_w != 0) begin
            trial = res + bit_w;
            if (n >= trial) begin
               n = n - trial;
               res = (res >> 1) + bit_w;
            end else begin
               res = res >> 1;
            end
            bit_w = bit_w >> 2;
         end
         return res[63:0];
      endfunction

      // Rounded t*d/2^32 with halves away from zero, sign taken from d.
      static function logic signed [63:0] offset_along(input logic signed [63:0] d,
                                                      input logic [63:0] t);
         logic [127:0] p;
         logic signed [63:0] m;
         p = (128'(abs64(d)) * 128'(t) + 128'h8000_0000) >> 32;
         m = p[63:0];
         return d < 0 ? -m : m;
      endfunction

      // Works out the distance and the zero-length flag for one query.
      static function psd_rsp_type predict_distance(input psd_req_type q);
         logic signed [63:0] dx, dy, px, py, ex, ey;
         logic signed [127:0] dot;
         logic [127:0] len2, d2;
         logic [63:0] t;
         psd_rsp_type r;
         dx = 64'(q.seg_end_x) - 64'(q.seg_start_x);
         dy = 64'(q.seg_end_y) - 64'(q.seg_start_y);
         px = 64'(q.point_x) - 64'(q.seg_start_x);
         py = 64'(q.point_y) - 64'(q.seg_start_y);
         len2 = 128'(abs64(dx)) * 128'(abs64(dx)) + 128'(abs64(dy)) * 128'(abs64(dy));
         dot = 128'(px) * 128'(dx) + 128'(py) * 128'(dy);
         t = 0;
         if (len2 != 0 && dot > 0) begin
            if (128'(dot) >= len2) t = 64'd1 << 32;
            else t = 64'((128'(dot) << 32) / len2);
         end
         ex = px - offset_along(dx, t);
         ey = py - offset_along(dy, t);
         d2 = 128'(abs64(ex)) * 128'(abs64(ex)) + 128'(abs64(ey)) * 128'(abs64(ey));
         r.distance = DistW'(root_floor(d2));
         r.degenerate = (len2 == 0);
         return r;
      endfunction

      function void note_query(input psd_req_type q);
         pending.insert(pending.size(), predict_distance(q));
      endfunction

      function void check_distance(input psd_rsp_type got);
         psd_rsp_type want;
         if (pending.size() == 0) begin
            $error("distance result with no query outstanding: %0d", got.distance);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
            errors++;
         end
         if (got.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, got %0d", want.degenerate, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   localparam int PipeLatency = 77;
   localparam int RandomQueries = 1700;
   localparam longint CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   psd_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   psd_rsp_type rsp_data;

   distance_scoreboard board = new();
   longint cycle_count = 0;
   // Idle and stall rates, in percent; the driver flips them per phase of the run.
   int send_idle_pct = 37;
   int recv_stall_pct = 37;
   // Set while the receiver is forced to hold off for a long stretch.
   bit hold_off = 1'b0;
   // Raised by the driver in the middle of the random queries to start the hold-off.
   bit hold_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   point_segment_distance dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Every rsp_ transfer is checked against the oldest expected distance. Sampling happens at
   // the edge, so the values seen are those from before any update in this time step.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_distance(rsp_data);
   end

   // The receiver: random stalls, except during a forced hold-off or a stall-free phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // A hold-off long enough to fill the pipeline and stall the input, counted here.
   initial begin
      int n;
      wait (hold_request);
      @(posedge clock);
      hold_off = 1'b1;
      for (n = 0; n < 300; n++) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offers one query and holds it until the block takes it. Random gaps come first, so that
   // valid goes low only between transfers and never in the same step it is raised again.
   task automatic send_query(input psd_req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_query(q);
   endtask

   // Lowers valid and waits until every expected distance has come back.
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19)) <<< 8;
      endcase
   endfunction

   function automatic psd_req_type random_query();
      psd_req_type q;
      int mode;
      mode = $urandom_range(3);
      q.point_x = pick_coord(mode);
      q.point_y = pick_coord(mode);
      q.seg_start_x = pick_coord(mode);
      q.seg_start_y = pick_coord(mode);
      q.seg_end_x = pick_coord(mode);
      q.seg_end_y = pick_coord(mode);
      // Mix in zero-length segments, horizontal ones and points that share the start's x.
      case ($urandom_range(9))
         0: begin
            q.seg_end_x = q.seg_start_x;
            q.seg_end_y = q.seg_start_y;
         end
         1: q.seg_end_y = q.seg_start_y;
         2: q.point_x = q.seg_start_x;
         default: ;
      endcase
      return q;
   endfunction

   function automatic psd_req_type make_query(input logic signed [31:0] qx, qy, sx, sy, ex, ey);
      psd_req_type q;
      q.point_x = qx;
      q.point_y = qy;
      q.seg_start_x = sx;
      q.seg_start_y = sy;
      q.seg_end_x = ex;
      q.seg_end_y = ey;
      return q;
   endfunction

   initial begin
      localparam logic signed [31:0] MaxC = 32'sh7FFF_FFFF;
      localparam logic signed [31:0] MinC = 32'sh8000_0000;
      localparam logic signed [31:0] One = 32'sh0001_0000;
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed queries: a zero-length segment, projections before the start, beyond the
      // end and inside, and the coordinate extremes in every corner.
      send_query(make_query(0, 0, 0, 0, 0, 0));
      send_query(make_query(One, One, 0, 0, 0, 0));
      send_query(make_query(MaxC, MaxC, MinC, MinC, MinC, MinC));
      send_query(make_query(-One, One, 0, 0, 4 * One, 0));
      send_query(make_query(9 * One, -One, 0, 0, 4 * One, 0));
      send_query(make_query(2 * One, 3 * One, 0, 0, 4 * One, 0));
      send_query(make_query(One, One, 0, 0, 2 * One, 2 * One));
      send_query(make_query(MaxC, MinC, MinC, MaxC, MaxC, MaxC));
      send_query(make_query(MinC, MaxC, MaxC, MinC, MinC, MinC));
      send_query(make_query(MaxC, MaxC, MinC, MinC, MaxC, MinC));
      send_query(make_query(MinC, MinC, MaxC, MaxC, MinC, MaxC));
      send_query(make_query(MinC, MinC, MinC, MinC, MaxC, MaxC));
      send_query(make_query(MaxC, MinC, MinC, MinC, MaxC, MaxC));
      send_query(make_query(-1, -1, 1, 1, 1, 2));
      send_query(make_query(1, 0, 0, 0, 3, 0));
      send_query(make_query(2, 1, 0, 0, 3, 1));
      send_query(make_query(32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 7, MaxC));
      send_query(make_query(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC));
      // The sender pauses here until every distance has come back.
      drain_all();

      for (i = 0; i < RandomQueries; i++) begin
         // A stretch of back-to-back transfers with no idling on either side.
         if (i == 400) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         if (i == 700) begin
            send_idle_pct = 37;
            recv_stall_pct = 37;
         end
         // The receiver holds off for a while as the sender keeps offering queries.
         if (i == 900) hold_request = 1'b1;
         if (i == 1200) drain_all();
         send_query(random_query());
      end
      drain_all();
      repeat (PipeLatency + 20) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
